>>> hdl/bcc_pkg.sv
// Shared types, codes and defaults of the button click classifier.
`timescale 1ns / 1ps
package bcc_pkg;

  localparam int TickWidthDefault = 32;
  localparam int CfgWidth = 16;
  localparam int CfgIndexWidth = 2;

  localparam logic [CfgIndexWidth-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_DOUBLE_CLICK = 2'd2;

  localparam logic [CfgWidth-1:0] DEBOUNCE_RESET = 16'd5;
  localparam logic [CfgWidth-1:0] LONG_PRESS_RESET = 16'd100;
  localparam logic [CfgWidth-1:0] DOUBLE_CLICK_RESET = 16'd30;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    S_IDLE    = 2'b01,
    S_PRESSED = 2'b10
  } press_state_t;

  typedef struct packed {
    logic [CfgWidth-1:0] debounce_ticks;
    logic [CfgWidth-1:0] long_press_ticks;
    logic [CfgWidth-1:0] double_click_ticks;
  } cfg_t;

endpackage

>>> hdl/button_click_classifier.sv
// Path: an accepted sample's event is loaded into the output register
// when the output stage is free; a stalled output holds the sample in the input stage.
// Throughput: one sample per clock while out_ready is high; input and output registers
// each take an item every cycle, and the classification is a single pass between them.
// Reset: synchronous, active high; clears the tick counter, press machine and
// both stages, and loads the default register values (5, 100, 30 ticks).
`timescale 1ns / 1ps
module button_click_classifier import bcc_pkg::*; #(
  parameter int TICK_WIDTH = TickWidthDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]      cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     raw_level,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               event_code
);

  cfg_t   cfg;
  logic   s1_valid;
  logic   s1_raw;
  logic   s1_adv;
  event_t ev;

  assign s1_adv = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= DEBOUNCE_RESET;
      cfg.long_press_ticks <= LONG_PRESS_RESET;
      cfg.double_click_ticks <= DOUBLE_CLICK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEBOUNCE:     cfg.debounce_ticks <= cfg_data;
        REG_LONG_PRESS:   cfg.long_press_ticks <= cfg_data;
        REG_DOUBLE_CLICK: cfg.double_click_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input stage: hold the sample until the classifier step takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_raw <= raw_level;
    end
  end

  bcc_core #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (s1_adv),
    .raw  (s1_raw),
    .cfg  (cfg),
    .ev   (ev)
  );

  // Output stage: hold the event until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      event_code <= ev;
    end
  end

`ifndef ASSERT_OFF
  a_reset_clears: assert property (@(posedge clk) rst |=> !s1_valid && !out_valid)
    else $error("stages not cleared by reset");
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |=> s1_valid && $stable(s1_raw))
    else $error("input stage lost an item while stalled");
  a_step_needs_slot: assert property (@(posedge clk) disable iff (rst)
    s1_adv |-> !out_valid || out_ready)
    else $error("classifier stepped into a full output stage");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_code))
    else $error("output item dropped while stalled");
`endif

endmodule

>>> hdl/bcc_core.sv
// Tick counter, debounce timer and press state machine of the classifier.
`timescale 1ns / 1ps
module bcc_core import bcc_pkg::*; #(
  parameter int TICK_WIDTH = TickWidthDefault
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   step,
  input  logic   raw,
  input  cfg_t   cfg,
  output event_t ev
);

  localparam int CmpWidth = (TICK_WIDTH > CfgWidth) ? TICK_WIDTH : CfgWidth;

  logic [TICK_WIDTH-1:0] tick_now, tick_now_next;
  logic                  previous_raw, previous_raw_next;
  logic [TICK_WIDTH-1:0] stable_since, stable_since_next;
  press_state_t          state, state_next;
  logic [TICK_WIDTH-1:0] press_start, press_start_next;
  logic [TICK_WIDTH-1:0] click_time, click_time_next;
  logic [1:0]            clicks_seen, clicks_seen_next;
  logic                  long_reported, long_reported_next;

  logic [TICK_WIDTH-1:0] el_stable, el_press, el_click;
  logic [1:0]            clicks_inc;
  logic                  done;

  assign tick_now_next = tick_now + TICK_WIDTH'(1);
  assign el_stable = tick_now - stable_since;
  assign el_press = tick_now - press_start;
  assign el_click = tick_now - click_time_next;
  assign clicks_inc = clicks_seen + 2'd1;

  always_comb begin
    previous_raw_next = previous_raw;
    stable_since_next = stable_since;
    state_next = state;
    press_start_next = press_start;
    click_time_next = click_time;
    clicks_seen_next = clicks_seen;
    long_reported_next = long_reported;
    ev = EV_NONE;
    done = 1'b0;
    if (raw != previous_raw) begin
      previous_raw_next = raw;
      stable_since_next = tick_now;
      done = 1'b1;
    end else if (CmpWidth'(el_stable) < CmpWidth'(cfg.debounce_ticks)) begin
      done = 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!raw) begin
            state_next = S_PRESSED;
            press_start_next = tick_now;
            long_reported_next = 1'b0;
          end
        end
        S_PRESSED: begin
          if (!long_reported &&
              CmpWidth'(el_press) >= CmpWidth'(cfg.long_press_ticks)) begin
            long_reported_next = 1'b1;
            clicks_seen_next = 2'd0;
            ev = EV_LONG;
            done = 1'b1;
          end else if (raw) begin
            state_next = S_IDLE;
            if (!long_reported) begin
              clicks_seen_next = clicks_inc;
              click_time_next = tick_now;
              if (clicks_inc == 2'd2) begin
                clicks_seen_next = 2'd0;
                ev = EV_DOUBLE;
                done = 1'b1;
              end
            end
          end
        end
        default: begin
          state_next = S_IDLE;
        end
      endcase
    end
    if (!done && clicks_seen_next == 2'd1 &&
        CmpWidth'(el_click) > CmpWidth'(cfg.double_click_ticks)) begin
      clicks_seen_next = 2'd0;
      ev = EV_SINGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_now <= '0;
      previous_raw <= 1'b1;
      stable_since <= '0;
      state <= S_IDLE;
      press_start <= '0;
      click_time <= '0;
      clicks_seen <= 2'd0;
      long_reported <= 1'b0;
    end else if (step) begin
      tick_now <= tick_now_next;
      previous_raw <= previous_raw_next;
      stable_since <= stable_since_next;
      state <= state_next;
      press_start <= press_start_next;
      click_time <= click_time_next;
      clicks_seen <= clicks_seen_next;
      long_reported <= long_reported_next;
    end
  end

endmodule
